// ===== sv/rhpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rhpt_pkg
// Shared constants for the Robin Hood pointer table: command and status codes,
// field widths and parameter defaults.
// ----------------------------------------------------------------------------
package rhpt_pkg;

   localparam int TABLE_SLOTS_DEF = 1024;
   localparam int KEY_BITS_DEF    = 48;
   localparam int HASH_SHIFT      = 3;

   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int SIZE_W  = 32;
   localparam int FLAGS_W = 8;
   localparam int CFG_W   = 11;
   localparam int COUNT_W = 11;

   localparam logic [CFG_W-1:0] SLOTS_RESET = 11'd1024;

   localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_FLAGS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_SIZE  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
   localparam logic [STAT_W-1:0] ST_PRESENT = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

endpackage

// ===== sv/rhpt_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rhpt_mod_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rhpt_mod_unit #(
   parameter int DIV_W = 45,
   parameter int REM_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [REM_W-1:0] divisor,
   output logic             done,
   output logic [REM_W-1:0] remainder
);

   localparam int CW = $clog2(DIV_W + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [REM_W-1:0] dsr_ff, dsr_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = CW'(DIV_W);
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = REM_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = REM_W'(trial);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/robin_hood_pointer_table.sv =====
// ----------------------------------------------------------------------------
// robin_hood_pointer_table
// Open-addressed Robin Hood hash table keyed by allocation address, with
// backward-shift delete. Entries carry size and flags.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/tready     | tuser: command; tdata: key,size,flags
//  rsp     | out | rsp_tvalid/tready     | tuser: status; tdata: size,flags,count
//  csr     | in  | csr_valid/csr_ready   | csr_data: slots_in_use
//
//  After reset a clearing pass writes every slot empty, with req_tready
//  low meanwhile (csr writes are taken).
//  Per transaction: the serial remainder unit hashes the key, then each
//  probed slot passes through read, check and act states, and the remainder
//  unit runs once more when a stored home must be reduced after a slot
//  count change.
//  Insert misses walk three times: find, empty-slot scan (read and check
//  per slot), then placement. Remove walks the shift chain, then clears the last hole.
//  One transaction at a time; a new one is taken while a result waits.
// ----------------------------------------------------------------------------
module robin_hood_pointer_table #(
   parameter int TABLE_SLOTS = rhpt_pkg::TABLE_SLOTS_DEF,
   parameter int KEY_BITS    = rhpt_pkg::KEY_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [rhpt_pkg::CMD_W-1:0] req_tuser,  // command
   // key, entry_size, entry_flags, zero pad
   input  logic [((KEY_BITS+40+7)/8)*8-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rhpt_pkg::STAT_W-1:0] rsp_tuser, // status
   output logic [55:0]                 rsp_tdata, // found_size, found_flags, entry_count, pad
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rhpt_pkg::CFG_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int KH_W   = KEY_BITS - rhpt_pkg::HASH_SHIFT;
   localparam int DIV_W  = (KH_W > IDX_W) ? KH_W : IDX_W;
   localparam int SZ     = rhpt_pkg::SIZE_W;
   localparam int FL     = rhpt_pkg::FLAGS_W;

   typedef struct packed {
      logic [CNT_W-1:0]    home;   // home slot plus one, zero when empty
      logic [KEY_BITS-1:0] key;
      logic [SZ-1:0]       size;
      logic [FL-1:0]       flags;
   } slot_type;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_HM    = 4'd4;
   localparam logic [3:0] S_HMW   = 4'd5;
   localparam logic [3:0] S_STEP  = 4'd6;
   localparam logic [3:0] S_WCLR  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   // walk phase
   localparam logic [1:0] P_FIND = 2'd0;
   localparam logic [1:0] P_SCAN = 2'd1;
   localparam logic [1:0] P_INS  = 2'd2;
   localparam logic [1:0] P_DEL  = 2'd3;

   slot_type mem [TABLE_SLOTS];
   slot_type rd_ff;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  ph_ff, ph_in;
   logic [rhpt_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SZ-1:0] size_ff, size_in;
   logic [FL-1:0] flags_ff, flags_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] hash_ff, hash_in, pos_ff, pos_in, hole_ff, hole_in, hm_ff, hm_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] j_ff, j_in;
   slot_type car_ff, car_in;
   logic [rhpt_pkg::STAT_W-1:0] st_ff, st_in;
   logic [SZ-1:0] osz_ff, osz_in;
   logic [FL-1:0] ofl_ff, ofl_in;
   logic [rhpt_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [rhpt_pkg::CFG_W-1:0] slots_ff, slots_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rhpt_pkg::STAT_W-1:0] rsp_st_ff, rsp_st_in;
   logic [SZ-1:0] rsp_sz_ff, rsp_sz_in;
   logic [FL-1:0] rsp_fl_ff, rsp_fl_in;
   logic [rhpt_pkg::COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // memory port controls
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_data;

   // remainder unit
   logic             mod_start, mod_done;
   logic [DIV_W-1:0] mod_dvd;
   logic [CNT_W-1:0] mod_dsr;
   logic [CNT_W-1:0] mod_rem;

   // probe arithmetic
   logic             occ, fast, jlast, req_acc;
   logic [CNT_W-1:0] hraw, pos_c, hm_c, pdist, n_eff;
   logic [IDX_W-1:0] nxt;
   logic [KEY_BITS-1:0] req_key;

   rhpt_mod_unit #(.DIV_W(DIV_W), .REM_W(CNT_W)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mod_dvd),
      .divisor  (mod_dsr),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   assign req_key = req_tdata[KEY_BITS-1:0];
   assign req_acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // slot count clamp: zero acts as one, large values as TABLE_SLOTS
   always_comb begin
      if (slots_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(slots_ff) > 32'(TABLE_SLOTS)) begin
         n_eff = CNT_W'(TABLE_SLOTS);
      end else begin
         n_eff = CNT_W'(slots_ff);
      end
   end

   assign occ   = (rd_ff.home != '0);
   assign hraw  = rd_ff.home - 1'b1;
   assign fast  = (hraw < n_ff);
   assign pos_c = CNT_W'(pos_ff);
   assign hm_c  = CNT_W'(hm_ff);
   assign pdist = (pos_c >= hm_c) ? (pos_c - hm_c) : (pos_c + n_ff - hm_c);
   assign nxt   = (pos_c + 1'b1 == n_ff) ? '0 : pos_ff + 1'b1;
   assign jlast = (j_ff + 1'b1 == n_ff);

   // hashing starts at the accept edge, before n_ff holds the new slot count
   always_comb begin
      mod_dvd = DIV_W'(hraw[IDX_W-1:0]);
      mod_dsr = n_ff;
      if (state_ff == S_IDLE) begin
         mod_dvd = DIV_W'(req_key[KEY_BITS-1:rhpt_pkg::HASH_SHIFT]);
         mod_dsr = n_eff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;  ph_in = ph_ff;   cmd_in = cmd_ff;
      key_in = key_ff;      size_in = size_ff; flags_in = flags_ff;
      n_in = n_ff;          hash_in = hash_ff; pos_in = pos_ff;
      hole_in = hole_ff;    hm_in = hm_ff;   clr_in = clr_ff;
      j_in = j_ff;          car_in = car_ff; st_in = st_ff;
      osz_in = osz_ff;      ofl_in = ofl_ff; cnt_in = cnt_ff;
      slots_in = slots_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_st_in = rsp_st_ff; rsp_sz_in = rsp_sz_ff;
      rsp_fl_in = rsp_fl_ff; rsp_cnt_in = rsp_cnt_ff;
      rd_en = 1'b0; wr_en = 1'b0; wr_addr = pos_ff; wr_data = rd_ff;
      mod_start = 1'b0;

      if (csr_valid) begin
         slots_in = csr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               cmd_in   = req_tuser;
               key_in   = req_key;
               size_in  = req_tdata[KEY_BITS +: SZ];
               flags_in = req_tdata[KEY_BITS+SZ +: FL];
               n_in     = n_eff;
               ph_in    = P_FIND;
               j_in     = '0;
               st_in    = rhpt_pkg::ST_MISSING;
               osz_in   = '0;
               ofl_in   = '0;
               if (req_tuser > rhpt_pkg::CMD_SET_SIZE) begin
                  state_in = S_DONE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (mod_done) begin
               hash_in  = IDX_W'(mod_rem);
               pos_in   = IDX_W'(mod_rem);
               state_in = S_RD;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_HM;
         end
         S_HM: begin
            if (ph_ff == P_SCAN) begin
               if (!occ) begin
                  ph_in  = P_INS;
                  pos_in = hash_ff;
                  j_in   = '0;
                  car_in = '{home: CNT_W'(hash_ff) + 1'b1, key: key_ff,
                             size: size_ff, flags: flags_ff};
                  state_in = S_RD;
               end else if (jlast) begin
                  st_in    = rhpt_pkg::ST_FULL;
                  state_in = S_DONE;
               end else begin
                  pos_in   = nxt;
                  j_in     = j_ff + 1'b1;
                  state_in = S_RD;
               end
            end else if (!occ || fast) begin
               hm_in    = hraw[IDX_W-1:0];
               state_in = S_STEP;
            end else begin
               // stored home lies beyond the current slot count
               mod_start = 1'b1;
               state_in  = S_HMW;
            end
         end
         S_HMW: begin
            if (mod_done) begin
               hm_in    = IDX_W'(mod_rem);
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            case (ph_ff)
               P_FIND: begin
                  if (occ && j_ff <= pdist && rd_ff.key == key_ff) begin
                     st_in    = rhpt_pkg::ST_OK;
                     osz_in   = rd_ff.size;
                     ofl_in   = rd_ff.flags;
                     state_in = S_DONE;
                     case (cmd_ff)
                        rhpt_pkg::CMD_INSERT: begin
                           st_in = rhpt_pkg::ST_PRESENT;
                        end
                        rhpt_pkg::CMD_SET_FLAGS: begin
                           wr_en   = 1'b1;
                           wr_data.flags = flags_ff;
                           ofl_in  = flags_ff;
                        end
                        rhpt_pkg::CMD_SET_SIZE: begin
                           wr_en   = 1'b1;
                           wr_data.size = size_ff;
                           osz_in  = size_ff;
                        end
                        rhpt_pkg::CMD_REMOVE: begin
                           wr_en   = 1'b1;
                           wr_data.home = '0;
                           if (cnt_ff != '0) begin
                              cnt_in = cnt_ff - 1'b1;
                           end
                           hole_in  = pos_ff;
                           pos_in   = nxt;
                           j_in     = '0;
                           ph_in    = P_DEL;
                           state_in = S_RD;
                        end
                        default: begin
                        end
                     endcase
                  end else if (!occ || j_ff > pdist || jlast) begin
                     if (cmd_ff == rhpt_pkg::CMD_INSERT) begin
                        ph_in    = P_SCAN;
                        pos_in   = hash_ff;
                        j_in     = '0;
                        state_in = S_RD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end else begin
                     pos_in   = nxt;
                     j_in     = j_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               P_INS: begin
                  pos_in = nxt;
                  state_in = S_RD;
                  if (!occ) begin
                     wr_en   = 1'b1;
                     wr_data = car_ff;
                     if (cnt_ff != '1) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                     st_in    = rhpt_pkg::ST_OK;
                     osz_in   = size_ff;
                     ofl_in   = flags_ff;
                     state_in = S_DONE;
                  end else if (j_ff >= pdist) begin
                     // richer resident: swap it out and carry it on
                     wr_en   = 1'b1;
                     wr_data = car_ff;
                     car_in  = rd_ff;
                     j_in    = pdist + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
               P_DEL: begin
                  if (!occ || pdist == '0) begin
                     state_in = S_WCLR;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = hole_ff;
                     hole_in = pos_ff;
                     pos_in  = nxt;
                     j_in    = j_ff + 1'b1;
                     state_in = jlast ? S_WCLR : S_RD;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WCLR: begin
            wr_en    = 1'b1;
            wr_addr  = hole_ff;
            wr_data  = '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = st_ff;
               rsp_sz_in    = osz_ff;
               rsp_fl_in    = ofl_ff;
               rsp_cnt_in   = cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         slots_ff     <= rhpt_pkg::SLOTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ph_ff <= ph_in;     cmd_ff <= cmd_in;   key_ff <= key_in;
      size_ff <= size_in; flags_ff <= flags_in; n_ff <= n_in;
      hash_ff <= hash_in; pos_ff <= pos_in;   hole_ff <= hole_in;
      hm_ff <= hm_in;     j_ff <= j_in;       car_ff <= car_in;
      st_ff <= st_in;     osz_ff <= osz_in;   ofl_ff <= ofl_in;
      rsp_st_ff <= rsp_st_in; rsp_sz_ff <= rsp_sz_in;
      rsp_fl_ff <= rsp_fl_in; rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {5'b0, rsp_cnt_ff, rsp_fl_ff, rsp_sz_ff};

   // held count moves by at most one per transaction
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(cnt_ff) |-> (cnt_ff == $past(cnt_ff) + 1'b1 ||
                            cnt_ff + 1'b1 == $past(cnt_ff)))
      else $error("held count jumped");

   // probes stay inside the slots in use
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (CNT_W'(pos_ff) < n_ff))
      else $error("probe beyond slot count");

   // remainder unit result is reduced
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (mod_rem < n_ff))
      else $error("remainder not reduced");

   // a result is only loaded from the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside done state");

endmodule
